/* sv/sha1_pkg.sv */
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 61;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned DigestN = 5;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_t;

  // byte sources for a buffer write
  typedef enum logic [1:0] {
    SRC_DATA, SRC_PAD, SRC_ZERO, SRC_LEN
  } bsrc_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_byte;    // write one byte at the current position
    bsrc_t      src;
    logic       cnt_inc;    // count a message byte
    logic       round_init; // load working vars from chain
    logic       round_step; // one compression round
    logic       fold;       // add working vars into chain
    logic       restart;    // chain and count back to reset
  } sha1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] pos;        // block position of next byte
    logic [6:0] round;      // round counter
  } sha1_sts_t;

endpackage

/* sv/sha1_if.sv */
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  modport source (output valid, opcode, data_byte, input ready);
  modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/sha1_datapath.sv */
module sha1_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1_pkg::sha1_cmd_t   cmd,
  input  logic [7:0]            data_byte,
  input  logic [2:0]            rd_idx,
  output sha1_pkg::sha1_sts_t   sts,
  output logic [31:0]           chain_word
);

  logic [31:0] chain_r [5];
  logic [31:0] buf_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [60:0] cnt_r;
  logic [5:0]  pos_r;
  logic [6:0]  round_r;
  logic [2:0]  len_r;   // which length byte is next

  logic [7:0]  wbyte;
  logic [63:0] bits;
  logic [31:0] f, k, t, w_new, w_cur;
  logic [1:0]  grp;

  assign bits = {cnt_r, 3'b000};

  // byte to write
  always_comb begin
    case (cmd.src)
      sha1_pkg::SRC_DATA: wbyte = data_byte;
      sha1_pkg::SRC_PAD:  wbyte = sha1_pkg::PadByte;
      sha1_pkg::SRC_LEN:  wbyte = bits[8'(7 - len_r) * 8 +: 8];
      default:            wbyte = 8'h00;
    endcase
  end

  // round function; schedule lives in buf_r as a 16-word window
  always_comb begin
    grp = 2'd3;
    if (round_r < 7'd20)      grp = 2'd0;
    else if (round_r < 7'd40) grp = 2'd1;
    else if (round_r < 7'd60) grp = 2'd2;
    case (grp)
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); k = sha1_pkg::K0; end
      2'd1: begin f = b_r ^ c_r ^ d_r;            k = sha1_pkg::K1; end
      2'd2: begin f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = sha1_pkg::K2; end
      default: begin f = b_r ^ c_r ^ d_r;         k = sha1_pkg::K3; end
    endcase
    w_new = buf_r[13] ^ buf_r[8] ^ buf_r[2] ^ buf_r[0];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = buf_r[0];
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      round_r <= '0;
      chain_r <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
    end else begin
      if (cmd.wr_byte) begin
        pos_r <= pos_r + 6'd1;
        if (cmd.src == sha1_pkg::SRC_LEN) len_r <= len_r + 3'd1;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + 61'd1;
      if (cmd.round_init) round_r <= '0;
      if (cmd.round_step) round_r <= round_r + 7'd1;
      if (cmd.fold) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.restart) begin
        cnt_r   <= '0;
        pos_r   <= '0;
        len_r   <= '0;
        chain_r <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                     sha1_pkg::H4};
      end
    end
  end

  // block buffer and working variables
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      if (pos_r[1:0] == 2'd0)
        buf_r[pos_r[5:2]] <= {wbyte, 24'h0};
      else
        buf_r[pos_r[5:2]][5'(3 - pos_r[1:0]) * 8 +: 8] <= wbyte;
    end
    if (cmd.round_init) begin
      a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2];
      d_r <= chain_r[3]; e_r <= chain_r[4];
    end
    if (cmd.round_step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) buf_r[i] <= buf_r[i + 1];
      buf_r[15] <= w_new;
    end
  end

  assign sts.pos   = pos_r;
  assign sts.round = round_r;
  assign chain_word = chain_r[rd_idx];

endmodule

/* sv/sha1_ctrl.sv */
module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 last_word,
  output sha1_pkg::sha1_cmd_t  cmd,
  input  sha1_pkg::sha1_sts_t  sts
);

  sha1_pkg::state_t state_r, state_nxt;
  logic       finishing_r, finishing_nxt; // end item in progress
  logic       padded_r, padded_nxt;       // 0x80 already written
  logic       len_ok_r, len_ok_nxt;       // length goes into this block
  logic [2:0] idx_r, idx_nxt;
  logic       len_done_r;                 // length written marks the final block
  logic       take;

  assign take = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt     = state_r;
    finishing_nxt = finishing_r;
    padded_nxt    = padded_r;
    len_ok_nxt    = len_ok_r;
    idx_nxt       = idx_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (take) begin
          if (in_opcode == sha1_pkg::OP_END) begin
            // 0x80 goes in on the accept cycle; a full block compresses first
            state_nxt = (sts.pos == 6'd63) ? sha1_pkg::ST_ROUND : sha1_pkg::ST_PAD;
            finishing_nxt = 1'b1;
            padded_nxt = 1'b1;
            len_ok_nxt = (sts.pos < 6'd56);
          end else if (sts.pos == 6'd63) begin
            state_nxt = sha1_pkg::ST_ROUND;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        padded_nxt = 1'b1;
        if (sts.pos == 6'd63) state_nxt = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        if (sts.round == 7'(sha1_pkg::Rounds - 1)) state_nxt = sha1_pkg::ST_FOLD;
      end
      sha1_pkg::ST_FOLD: begin
        if (!finishing_r) state_nxt = sha1_pkg::ST_IDLE;
        else if (padded_r && sts.pos == 6'd0 && len_done_r) begin
          state_nxt = sha1_pkg::ST_EMIT;
          idx_nxt = '0;
        end else begin
          state_nxt = sha1_pkg::ST_PAD;
          len_ok_nxt = 1'b1;
        end
      end
      sha1_pkg::ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(sha1_pkg::DigestN - 1)) begin
            state_nxt = sha1_pkg::ST_IDLE;
            finishing_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      finishing_r <= 1'b0;
      padded_r    <= 1'b0;
      len_ok_r    <= 1'b0;
      idx_r       <= '0;
      len_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finishing_r <= finishing_nxt;
      padded_r    <= padded_nxt;
      len_ok_r    <= len_ok_nxt;
      idx_r       <= idx_nxt;
      if (state_r == sha1_pkg::ST_IDLE) len_done_r <= 1'b0;
      else if (state_r == sha1_pkg::ST_PAD && len_ok_r && sts.pos == 6'd63)
        len_done_r <= 1'b1;
    end
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd.src = sha1_pkg::SRC_DATA;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (take) begin
          cmd.wr_byte = 1'b1;
          if (in_opcode == sha1_pkg::OP_END) cmd.src = sha1_pkg::SRC_PAD;
          else cmd.cnt_inc = 1'b1;
        end
        cmd.round_init = 1'b1;
      end
      sha1_pkg::ST_PAD: begin
        cmd.wr_byte = 1'b1;
        if (!padded_r) cmd.src = sha1_pkg::SRC_PAD;
        else if (len_ok_r && sts.pos >= 6'd56) cmd.src = sha1_pkg::SRC_LEN;
        else cmd.src = sha1_pkg::SRC_ZERO;
        cmd.round_init = 1'b1;
      end
      sha1_pkg::ST_ROUND: cmd.round_step = 1'b1;
      sha1_pkg::ST_FOLD:  cmd.fold = 1'b1;
      sha1_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && idx_r == 3'(sha1_pkg::DigestN - 1)) cmd.restart = 1'b1;
      end
      default: ;
    endcase
  end

  assign word_index = idx_r;
  assign last_word  = (idx_r == 3'(sha1_pkg::DigestN - 1));

endmodule

/* sv/sha1_message_digest.sv */
// SHA-1 digest engine. A data transaction adds one message byte; the 64th
// byte of a block also starts the 80 rounds (one per cycle in the shared
// round unit) and the chain fold, and no input is taken until they are done.
// An end transaction pads the message one byte per cycle, pausing to
// compress each full block, compresses the last one or two blocks, then
// offers the five digest words h0..h4 in order, last_word on the fifth; chain
// and byte count then return to their reset values for the next message. No clearing pass.
module sha1_message_digest (
  input logic clk,
  input logic rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  sha1_pkg::sha1_cmd_t cmd;
  sha1_pkg::sha1_sts_t sts;
  logic [2:0] idx;

  sha1_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_opcode(in_ch.opcode), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(idx), .last_word(out_ch.last_word),
    .cmd, .sts
  );

  sha1_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_ch.data_byte),
    .rd_idx(idx), .sts, .chain_word(out_ch.digest_word)
  );

  assign out_ch.word_index = idx;

  // no input taken while a digest is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input and output overlap");
  // last word only on index four
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_word == (idx == 3'd4))) else $error("last_word");
  // index stays in range
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> idx <= 3'd4) else $error("word index");

endmodule

/* dv/sha1_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts digest words and compares them in order.
module sha1_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0] out_word_index,
  input  logic out_last_word,
  output int unsigned fail_count,
  output int unsigned pending_words,
  output int unsigned digests_seen
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] chain_h [5];
  logic [31:0] blk_words [16];
  logic [60:0] byte_cnt;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic chain_reset();
    chain_h[0] = sha1_pkg::H0; chain_h[1] = sha1_pkg::H1; chain_h[2] = sha1_pkg::H2;
    chain_h[3] = sha1_pkg::H3; chain_h[4] = sha1_pkg::H4;
    byte_cnt = '0;
  endtask

  // 80-round compression of the buffered block into the chain
  task automatic compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = sha1_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  task automatic put_byte(logic [5:0] pos, logic [7:0] v);
    if (pos[1:0] == 2'd0) blk_words[pos[5:2]] = {v, 24'd0};
    else blk_words[pos[5:2]] |= 32'(v) << ((3 - pos[1:0]) * 8);
    if (pos == 6'd63) compress();
  endtask

  // end of message: pad, append bit length, queue five words
  task automatic finish_message();
    logic [5:0] pos;
    logic [63:0] bits;
    digest_word_t dw;
    pos = byte_cnt[5:0];
    put_byte(pos, sha1_pkg::PadByte);
    pos++;
    while (pos != 6'd56) begin
      put_byte(pos, 8'h00);
      pos++;
    end
    bits = {byte_cnt, 3'b000};
    for (int i = 0; i < 8; i++) begin
      put_byte(pos, bits[63 - 8*i -: 8]);
      pos++;
    end
    for (int i = 0; i < 5; i++) begin
      dw.word = chain_h[i]; dw.idx = 3'(i); dw.last = (i == 4);
      digest_q.push_back(dw);
    end
    chain_reset();
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      chain_reset();
      digest_q.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_opcode == sha1_pkg::OP_DATA) begin
          put_byte(byte_cnt[5:0], in_data_byte);
          byte_cnt++;
        end else begin
          finish_message();
        end
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, out_digest_word,
                   out_word_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w != {out_digest_word, out_word_index, out_last_word}) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_w.word, exp_w.idx, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
            fail_count <= fail_count + 1;
          end
          if (out_last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic quiet_tail = 1'b0;
  int unsigned fail_count, pending_words, digests_seen;
  int unsigned stall_cnt = 0;
  int unsigned msg_count = 0;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_message_digest i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  sha1_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_opcode(in_ch.opcode), .in_data_byte(in_ch.data_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_digest_word(out_ch.digest_word), .out_word_index(out_ch.word_index),
    .out_last_word(out_ch.last_word),
    .fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    int unsigned hold;
    if (!rst_n || quiet_tail) begin
      out_ch.ready <= rst_n;
    end else if (out_ch.ready && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      hold = $urandom_range(1, 3);
      repeat (hold) @(posedge clk);
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 5000) begin
      $display("watchdog expired");
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays high between back to back items; it drops only for a gap
  task automatic send(logic op, logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (op == sha1_pkg::OP_END) msg_count++;
  endtask

  task automatic send_message(int unsigned len, bit pattern);
    for (int i = 0; i < len; i++)
      send(sha1_pkg::OP_DATA,
           pattern ? 8'((i & 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
    send(sha1_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    in_ch.valid = 1'b0;
    in_ch.opcode = sha1_pkg::OP_DATA;
    in_ch.data_byte = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, end with byte ignored, "abc", padding edges
    send(sha1_pkg::OP_END, 8'h00);
    send(sha1_pkg::OP_END, 8'hFF);
    send(sha1_pkg::OP_DATA, 8'h61); send(sha1_pkg::OP_DATA, 8'h62);
    send(sha1_pkg::OP_DATA, 8'h63);
    send(sha1_pkg::OP_END, 8'h00);
    send_message(1, 1'b1);
    send_message(4, 1'b1);
    // hold until all digests are out
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b0);
    sent = 0;
    // random messages, mostly short, a few over one block
    while (sent < 180) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 130) : $urandom_range(0, 20);
      if (sent > 140) quiet_tail = 1'b1;
      send_message(len, 1'b0);
      sent += len + 1;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d messages, %0d digests compared", msg_count, digests_seen);
    $display("covered empty, short, block-boundary and multi-block messages");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
sv/sha1_pkg.sv
sv/sha1_if.sv
sv/sha1_datapath.sv
sv/sha1_ctrl.sv
sv/sha1_message_digest.sv
dv/sha1_checker.sv
dv/tb.sv
